@@ sv/ttw_pkg.sv @@
// Shared types and constants of the text terminal writer.
// Used by the channel interfaces, the controller, the datapath and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

   localparam int MAX_COLS   = 80;
   localparam int MAX_ROWS   = 25;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   localparam int OPCODE_W   = 2;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 11;
   localparam int CELL_W     = 16;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int COLOR_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ROWS = 2'd2;

   localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0]  CHAR_BLANK   = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd240;
   localparam logic [COL_W-1:0]   RESET_COLS   = 7'd80;
   localparam logic [ROW_W-1:0]   RESET_ROWS   = 5'd25;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_INIT_WR,
      ACT_ACCEPT,
      ACT_PUT,
      ACT_NEWLINE,
      ACT_SCROLL_START,
      ACT_SCROLL_RD,
      ACT_SCROLL_WR,
      ACT_BLANK_START,
      ACT_BLANK_WR,
      ACT_CLEAR,
      ACT_READ,
      ACT_CAPTURE,
      ACT_LOAD
   } dp_action_type;

   typedef struct packed {
      dp_action_type action;
   } dp_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                newline;
      logic                last_row;
      logic                read_in_range;
      logic                ptr_at_end;
      logic                init_last;
      logic                rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ sv/ttw_if.sv @@
// Valid/ready channel interfaces of the text terminal writer: request, response, register write.
// Depends on ttw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ttw_req_if;
   import ttw_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CHAR_W-1:0]   char_code;
   logic [IDX_W-1:0]    cell_index;
   modport source (output valid, opcode, char_code, cell_index, input ready);
   modport sink   (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface ttw_rsp_if;
   import ttw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;
   logic [ROW_W-1:0]  row_now;
   logic [COL_W-1:0]  col_now;
   modport source (output valid, cell_value, row_now, col_now, input ready);
   modport sink   (input valid, cell_value, row_now, col_now, output ready);
endinterface

interface ttw_csr_if;
   import ttw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/ttw_ctrl.sv @@
// Sequencing state machine of the text terminal writer.
// Depends on ttw_pkg; drives the datapath through dp_cmd_type, reads dp_status_type.
`timescale 1ns / 1ps
`default_nettype none

module ttw_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  ttw_pkg::dp_status_type status,
   output ttw_pkg::dp_cmd_type    cmd
);
   import ttw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (status.opcode)
               OP_PUT: begin
                  if (status.newline && status.last_row) state_in = ST_SCROLL_RD;
                  else state_in = ST_DONE;
               end
               OP_CLEAR: state_in = ST_BLANK;
               OP_READ: begin
                  if (status.read_in_range) state_in = ST_READ_WAIT;
                  else state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCROLL_RD: begin
            if (status.ptr_at_end) state_in = ST_BLANK;
            else state_in = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: state_in = ST_SCROLL_RD;
         ST_BLANK: begin
            if (status.ptr_at_end) state_in = ST_DONE;
         end
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.action = ACT_NONE;
      case (state_ff)
         ST_INIT: cmd.action = ACT_INIT_WR;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.action = ACT_ACCEPT;
         end
         ST_EXEC: begin
            case (status.opcode)
               OP_PUT: begin
                  if (!status.newline) cmd.action = ACT_PUT;
                  else if (status.last_row) cmd.action = ACT_SCROLL_START;
                  else cmd.action = ACT_NEWLINE;
               end
               OP_CLEAR: cmd.action = ACT_CLEAR;
               OP_READ: begin
                  if (status.read_in_range) cmd.action = ACT_READ;
               end
               default: cmd.action = ACT_NONE;
            endcase
         end
         ST_SCROLL_RD: begin
            if (status.ptr_at_end) cmd.action = ACT_BLANK_START;
            else cmd.action = ACT_SCROLL_RD;
         end
         ST_SCROLL_WR: cmd.action = ACT_SCROLL_WR;
         ST_BLANK: begin
            if (!status.ptr_at_end) cmd.action = ACT_BLANK_WR;
         end
         ST_READ_WAIT: cmd.action = ACT_CAPTURE;
         ST_DONE: begin
            if (status.rsp_free) cmd.action = ACT_LOAD;
         end
         default: cmd.action = ACT_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ sv/ttw_datapath.sv @@
// Datapath of the text terminal writer: registers, cursor, cell memory, walk pointer, response.
// Depends on ttw_pkg; commanded by ttw_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ttw_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  ttw_pkg::dp_cmd_type              cmd,
   output ttw_pkg::dp_status_type           status,
   input  wire [ttw_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire [ttw_pkg::CHAR_W-1:0]        req_char_code,
   input  wire [ttw_pkg::IDX_W-1:0]         req_cell_index,
   input  wire                              csr_valid,
   input  wire [ttw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [ttw_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [ttw_pkg::CELL_W-1:0]       rsp_cell_value,
   output logic [ttw_pkg::ROW_W-1:0]        rsp_row_now,
   output logic [ttw_pkg::COL_W-1:0]        rsp_col_now
);
   import ttw_pkg::*;

   localparam int CMP_W = IDX_W + CNT_W;

   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic [COLOR_W-1:0]  color_ff,    color_in;
   logic [COL_W-1:0]    cols_cfg_ff, cols_cfg_in;
   logic [ROW_W-1:0]    rows_cfg_ff, rows_cfg_in;
   logic [OPCODE_W-1:0] opcode_ff,   opcode_in;
   logic [CHAR_W-1:0]   char_ff,     char_in;
   logic [IDX_W-1:0]    idx_ff,      idx_in;
   logic [ROW_W-1:0]    row_ff,      row_in;
   logic [COL_W-1:0]    col_ff,      col_in;
   logic [CNT_W-1:0]    addr_ff,     addr_in;
   logic [CNT_W-1:0]    total_ff,    total_in;
   logic [CNT_W-1:0]    ptr_ff,      ptr_in;
   logic [CELL_W-1:0]   value_ff,    value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [ROW_W-1:0]    rsp_row_ff,   rsp_row_in;
   logic [COL_W-1:0]    rsp_col_ff,   rsp_col_in;

   logic [COL_W-1:0] act_cols;
   logic [ROW_W-1:0] act_rows;
   logic [ROW_W-1:0] sat_row;
   logic [COL_W-1:0] sat_col;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;

   always_comb begin
      if (cols_cfg_ff == '0) act_cols = COL_W'(1);
      else if (cols_cfg_ff > COL_W'(MAX_COLS)) act_cols = COL_W'(MAX_COLS);
      else act_cols = cols_cfg_ff;
      if (rows_cfg_ff == '0) act_rows = ROW_W'(1);
      else if (rows_cfg_ff > ROW_W'(MAX_ROWS)) act_rows = ROW_W'(MAX_ROWS);
      else act_rows = rows_cfg_ff;
   end

   assign sat_row = (row_ff >= act_rows) ? act_rows - ROW_W'(1) : row_ff;
   assign sat_col = (col_ff >= act_cols) ? act_cols - COL_W'(1) : col_ff;
   assign col_inc = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign row_inc = {1'b0, row_ff} + (ROW_W + 1)'(1);

   always_comb begin
      status.opcode        = opcode_ff;
      status.newline       = (char_ff == CHAR_NEWLINE);
      status.last_row      = (row_inc >= {1'b0, act_rows});
      status.read_in_range = (CMP_W'(idx_ff) < CMP_W'(total_ff));
      status.ptr_at_end    = (ptr_ff >= total_ff);
      status.init_last     = (ptr_ff == CNT_W'(CELL_COUNT - 1));
      status.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff[ADDR_W-1:0];
      mem_wdata = {color_ff, CHAR_BLANK};
      mem_re    = 1'b0;
      mem_raddr = ptr_ff[ADDR_W-1:0];
      case (cmd.action)
         ACT_INIT_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {RESET_COLOR, CHAR_BLANK};
         end
         ACT_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff[ADDR_W-1:0];
            mem_wdata = {color_ff, char_ff};
         end
         ACT_SCROLL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(ptr_ff - CNT_W'(act_cols));
            mem_wdata = rdata_ff;
         end
         ACT_BLANK_WR: mem_we = 1'b1;
         ACT_SCROLL_RD: mem_re = 1'b1;
         ACT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(idx_ff);
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      color_in    = color_ff;
      cols_cfg_in = cols_cfg_ff;
      rows_cfg_in = rows_cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TEXT_COLOR:  color_in    = csr_data[COLOR_W-1:0];
            CSR_SCREEN_COLS: cols_cfg_in = csr_data[COL_W-1:0];
            CSR_SCREEN_ROWS: rows_cfg_in = csr_data[ROW_W-1:0];
            default:         color_in    = color_ff;
         endcase
      end

      opcode_in    = opcode_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      addr_in      = addr_ff;
      total_in     = total_ff;
      ptr_in       = ptr_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;

      case (cmd.action)
         ACT_INIT_WR: ptr_in = ptr_ff + CNT_W'(1);
         ACT_ACCEPT: begin
            opcode_in = req_opcode;
            char_in   = req_char_code;
            idx_in    = req_cell_index;
            row_in    = sat_row;
            col_in    = sat_col;
            addr_in   = CNT_W'(sat_row) * CNT_W'(act_cols) + CNT_W'(sat_col);
            total_in  = CNT_W'(act_rows) * CNT_W'(act_cols);
            value_in  = '0;
         end
         ACT_PUT: begin
            if (col_inc >= {1'b0, act_cols}) begin
               col_in = '0;
               if (row_inc >= {1'b0, act_rows}) row_in = '0;
               else row_in = row_inc[ROW_W-1:0];
            end else begin
               col_in = col_inc[COL_W-1:0];
            end
         end
         ACT_NEWLINE: begin
            row_in = row_inc[ROW_W-1:0];
            col_in = '0;
         end
         ACT_SCROLL_START: begin
            ptr_in = CNT_W'(act_cols);
            row_in = act_rows - ROW_W'(1);
            col_in = '0;
         end
         ACT_SCROLL_WR: ptr_in = ptr_ff + CNT_W'(1);
         ACT_BLANK_START: ptr_in = total_ff - CNT_W'(act_cols);
         ACT_BLANK_WR: ptr_in = ptr_ff + CNT_W'(1);
         ACT_CLEAR: begin
            ptr_in = '0;
            row_in = '0;
            col_in = '0;
         end
         ACT_CAPTURE: value_in = rdata_ff;
         ACT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = value_ff;
            rsp_row_in   = row_ff;
            rsp_col_in   = col_ff;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= RESET_COLOR;
         cols_cfg_ff  <= RESET_COLS;
         rows_cfg_ff  <= RESET_ROWS;
         row_ff       <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         cols_cfg_ff  <= cols_cfg_in;
         rows_cfg_ff  <= rows_cfg_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff    <= opcode_in;
      char_ff      <= char_in;
      idx_ff       <= idx_in;
      addr_ff      <= addr_in;
      total_ff     <= total_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_row_now    = rsp_row_ff;
   assign rsp_col_now    = rsp_col_ff;

endmodule

`default_nettype wire

@@ sv/text_terminal_writer_unit.sv @@
// Top level of the text terminal writer: controller and datapath joined by command and status.
// Depends on ttw_pkg, ttw_if, ttw_ctrl and ttw_datapath.
//
// Text terminal over a 2000-cell screen memory (16-bit cells, attribute high, character low),
// one request in flight at a time; register writes are taken in every cycle and must only be
// issued while no request is outstanding. After reset a clearing pass writes every cell blank in
// colour 240, one cell a cycle, and requests are held off until it ends. A clear blanks all
// rows*cols cells, and a newline on the bottom row copies each row below the top one row up and
// then blanks the bottom row: the cell memory has one write port and one read port, and a scroll
// copy needs a read and a write per cell. One finished result is held in the response register,
// and the next request is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_writer_unit (
   input  wire        clock,
   input  wire        reset,
   ttw_req_if.sink    req_port,
   ttw_rsp_if.source  rsp_port,
   ttw_csr_if.sink    csr_port
);
   import ttw_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ctrl_ready;

   ttw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_port.opcode),
      .req_char_code  (req_port.char_code),
      .req_cell_index (req_port.cell_index),
      .csr_valid      (csr_port.valid),
      .csr_index      (csr_port.index),
      .csr_data       (csr_port.data),
      .rsp_valid      (rsp_port.valid),
      .rsp_ready      (rsp_port.ready),
      .rsp_cell_value (rsp_port.cell_value),
      .rsp_row_now    (rsp_port.row_now),
      .rsp_col_now    (rsp_port.col_now)
   );

   assign req_port.ready = ctrl_ready;
   assign csr_port.ready = 1'b1;

endmodule

`default_nettype wire

@@ sv/ttw_checker.sv @@
// Port-level checks of the text terminal writer and their binding to the top level.
// Depends on ttw_pkg and text_terminal_writer_unit.
`timescale 1ns / 1ps
`default_nettype none

module ttw_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [ttw_pkg::CELL_W-1:0]   rsp_cell_value,
   input wire [ttw_pkg::ROW_W-1:0]    rsp_row_now,
   input wire [ttw_pkg::COL_W-1:0]    rsp_col_now
);
   import ttw_pkg::*;

   // hold requests off just after reset, as the screen clearing pass begins
   a_init_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_now < ROW_W'(MAX_ROWS)) && (rsp_col_now < COL_W'(MAX_COLS)))
      else $error("cursor outside screen");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
         && $stable(rsp_row_now) && $stable(rsp_col_now))
      else $error("stalled response changed");

endmodule

bind text_terminal_writer_unit ttw_checker u_ttw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_cell_value (rsp_port.cell_value),
   .rsp_row_now    (rsp_port.row_now),
   .rsp_col_now    (rsp_port.col_now)
);

`default_nettype wire
